FILE: design/gfpe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfpe_pkg
// Shared types, register indexes and GF(2^8) arithmetic for the parity encoder.
// ----------------------------------------------------------------------------
package gfpe_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_DATA_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARITY_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_POLY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW0    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW2    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW3    = 3'd6;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctrl_t;

    // shift-and-add multiply modulo x^8 + poly
    function automatic byte_t gf_mul(input byte_t a_in, input byte_t b_in, input byte_t poly);
        byte_t a;
        byte_t acc;
        a   = a_in;
        acc = '0;
        for (int k = 0; k < BYTE_W; k++) begin
            if (b_in[k]) begin
                acc = acc ^ a;
            end
            if (a[BYTE_W-1]) begin
                a = {a[BYTE_W-2:0], 1'b0} ^ poly;
            end else begin
                a = {a[BYTE_W-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

endpackage
`default_nettype wire

FILE: design/gfpe_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfpe_lane
// One data lane: multiplies its data byte by the coefficient of every parity
// row (zero when the lane is inactive) and registers the products.
// ----------------------------------------------------------------------------
module gfpe_lane
    import gfpe_pkg::*;
#(
    parameter int PARITY_LANES = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          load,
    input  wire logic                          active,
    input  wire byte_t                         data_byte,
    input  wire byte_t                         poly,
    input  wire logic [PARITY_LANES-1:0][BYTE_W-1:0] coef,
    output logic      [PARITY_LANES-1:0][BYTE_W-1:0] prod
);

    logic [PARITY_LANES-1:0][BYTE_W-1:0] prod_reg;
    logic [PARITY_LANES-1:0][BYTE_W-1:0] prod_next;

    always_comb begin
        for (int j = 0; j < PARITY_LANES; j++) begin
            prod_next[j] = active ? gf_mul(coef[j], data_byte, poly) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

FILE: design/gfpe_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfpe_merge
// XORs the lane products per parity row, zeroes inactive rows and holds the
// result transaction in the output register.
// ----------------------------------------------------------------------------
module gfpe_merge
    import gfpe_pkg::*;
#(
    parameter int DATA_LANES   = 8,
    parameter int PARITY_LANES = 4
) (
    input  wire logic                                              aclk,
    input  wire logic                                              aresetn,
    input  wire stage_ctrl_t                                       ctrl,
    input  wire logic [DATA_LANES-1:0][PARITY_LANES-1:0][BYTE_W-1:0] prods,
    input  wire logic [2:0]                                        parity_count,
    output logic                                                   stage_ready,
    output logic                                                   m_valid,
    input  wire logic                                              m_ready,
    output logic [31:0]                                            m_parity_bytes,
    output logic                                                   m_last_out
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] parity_reg;
    logic [31:0] parity_next;
    logic        last_reg;
    logic        load;

    assign stage_ready = !valid_reg || m_ready;
    assign load        = ctrl.valid && stage_ready;

    always_comb begin
        byte_t acc;
        parity_next = '0;
        for (int j = 0; j < PARITY_LANES; j++) begin
            acc = '0;
            for (int i = 0; i < DATA_LANES; i++) begin
                acc = acc ^ prods[i][j];
            end
            if (3'(j) < parity_count) begin
                parity_next[BYTE_W*j +: BYTE_W] = acc;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            parity_reg <= parity_next;
            last_reg   <= ctrl.last;
        end
    end

    assign m_valid        = valid_reg;
    assign m_parity_bytes = parity_reg;
    assign m_last_out     = last_reg;

endmodule
`default_nettype wire

FILE: design/gf256_erasure_parity_encoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gf256_erasure_parity_encoder_top
// GF(2^8) erasure parity encoder: parity row j is the XOR over lanes of
// coefficient times data byte, with a configurable reduction polynomial.
// ----------------------------------------------------------------------------
// One stripe position is taken per cycle while s_ready is high. Its parity
// word passes two register stages: the first holds the per-lane GF(2^8)
// products, the second holds the XOR-merged parity bytes and drives the
// result channel. While a finished result waits on m_ready, a new transaction
// is still accepted if the product stage is empty. Registers (by cfg_index):
// 0 data_count, 1 parity_count, 2 field_poly, 3..6 coefficient rows 0..3;
// other indexes are ignored. Configure only while no transaction is in flight.
// ----------------------------------------------------------------------------
module gf256_erasure_parity_encoder_top
    import gfpe_pkg::*;
#(
    parameter int DATA_LANES   = 8,
    parameter int PARITY_LANES = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [63:0]          s_data_bytes,
    input  wire logic                 s_last_in,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [31:0]               m_parity_bytes,
    output logic                      m_last_out
);

    logic [3:0]  data_count_reg;
    logic [2:0]  parity_count_reg;
    byte_t       poly_reg;
    logic [PARITY_LANES-1:0][DATA_LANES-1:0][BYTE_W-1:0] coef_reg;

    logic [DATA_LANES-1:0][PARITY_LANES-1:0][BYTE_W-1:0] lane_coef;
    logic [DATA_LANES-1:0][PARITY_LANES-1:0][BYTE_W-1:0] prods;

    logic        v1_reg;
    logic        v1_next;
    logic        last1_reg;
    logic        stage_ready;
    logic        accept;
    stage_ctrl_t ctrl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_count_reg   <= 4'd8;
            parity_count_reg <= 3'd4;
            poly_reg         <= 8'h1D;
            coef_reg         <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index) inside
                REG_DATA_COUNT:   data_count_reg   <= cfg_wdata[3:0];
                REG_PARITY_COUNT: parity_count_reg <= cfg_wdata[2:0];
                REG_FIELD_POLY:   poly_reg         <= cfg_wdata[BYTE_W-1:0];
                REG_COEF_ROW0, REG_COEF_ROW1, REG_COEF_ROW2, REG_COEF_ROW3: begin
                    for (int r = 0; r < PARITY_LANES; r++) begin
                        if (cfg_index == REG_COEF_ROW0 + CFG_IDX_W'(r)) begin
                            for (int i = 0; i < DATA_LANES; i++) begin
                                coef_reg[r][i] <= cfg_wdata[BYTE_W*i +: BYTE_W];
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < DATA_LANES; i++) begin
            for (int j = 0; j < PARITY_LANES; j++) begin
                lane_coef[i][j] = coef_reg[j][i];
            end
        end
    end

    assign s_ready = !v1_reg || stage_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        v1_next = v1_reg;
        if (accept) begin
            v1_next = 1'b1;
        end else if (stage_ready) begin
            v1_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last1_reg <= s_last_in;
        end
    end

    for (genvar gi = 0; gi < DATA_LANES; gi++) begin : g_lane
        gfpe_lane #(
            .PARITY_LANES(PARITY_LANES)
        ) u_lane (
            .aclk      (aclk),
            .load      (accept),
            .active    (4'(gi) < data_count_reg),
            .data_byte (s_data_bytes[BYTE_W*gi +: BYTE_W]),
            .poly      (poly_reg),
            .coef      (lane_coef[gi]),
            .prod      (prods[gi])
        );
    end

    assign ctrl = '{valid: v1_reg, last: last1_reg};

    gfpe_merge #(
        .DATA_LANES  (DATA_LANES),
        .PARITY_LANES(PARITY_LANES)
    ) u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .prods          (prods),
        .parity_count   (parity_count_reg),
        .stage_ready    (stage_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_parity_bytes (m_parity_bytes),
        .m_last_out     (m_last_out)
    );

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && m_valid))
        else $error("input stalled with a free pipeline stage");

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> v1_reg)
        else $error("accepted transaction not held in product stage");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !stage_ready) |=> (v1_reg && $stable(last1_reg)))
        else $error("product stage lost a stalled transaction");

    a_no_parity_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && parity_count_reg == 3'd0) |-> (m_parity_bytes == 32'd0))
        else $error("parity produced with zero parity count");

endmodule
`default_nettype wire
